FILE: rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL converter package
// Shared payload types, divider cell types and sizes.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int CHAN_W  = 8;
    localparam int QUOT_W  = 9;   // quotient bits, one divider cell each
    localparam int REM_W   = 11;  // partial remainder and divisor width
    localparam int NUM_W   = 11;  // hue numerator width
    localparam int LATENCY = QUOT_W + 2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] lightness;
    } hsl_result_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  divisor;
        logic [QUOT_W-1:0] shift;   // dividend bits out, quotient bits in
    } div_lane_t;

    typedef struct packed {
        logic              gray;
        logic [CHAN_W-1:0] lightness;
        div_lane_t         sat;
        div_lane_t         hue;
    } stage_data_t;

endpackage

FILE: rtl/hsl_front.sv
// ----------------------------------------------------------------------------
// HSL front end
// Finds max and min, forms lightness and loads both divider lanes.
// ----------------------------------------------------------------------------
module hsl_front
    import hsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  rgb_pixel_t  pixel,
    output logic        valid,
    output stage_data_t data
);

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W:0]   sum;
    logic [CHAN_W-1:0] delta;
    logic [REM_W-1:0]  delta_w;
    logic [REM_W-1:0]  delta6;
    logic [REM_W-1:0]  sat_div;
    logic [NUM_W-1:0]  hue_num;
    logic              valid_reg;
    stage_data_t       data_reg;
    stage_data_t       data_next;

    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx)
        begin
            mx = pixel.green;
        end
        if (pixel.blue > mx)
        begin
            mx = pixel.blue;
        end
        if (pixel.green < mn)
        begin
            mn = pixel.green;
        end
        if (pixel.blue < mn)
        begin
            mn = pixel.blue;
        end
    end

    assign sum     = {1'b0, mx} + {1'b0, mn};
    assign delta   = mx - mn;
    assign delta_w = {{(REM_W-CHAN_W){1'b0}}, delta};
    assign delta6  = (delta_w << 2) + (delta_w << 1);
    assign sat_div = sum[CHAN_W] ? (REM_W'(512) - REM_W'(sum)) : REM_W'(sum);

    always_comb
    begin
        priority if (pixel.red == mx)
        begin
            if (pixel.green >= pixel.blue)
            begin
                hue_num = NUM_W'(pixel.green) - NUM_W'(pixel.blue);
            end
            else
            begin
                hue_num = delta6 - (NUM_W'(pixel.blue) - NUM_W'(pixel.green));
            end
        end
        else if (pixel.green == mx)
        begin
            hue_num = (delta_w << 1) + NUM_W'(pixel.blue) - NUM_W'(pixel.red);
        end
        else
        begin
            hue_num = (delta_w << 2) + NUM_W'(pixel.red) - NUM_W'(pixel.green);
        end
    end

    always_comb
    begin
        data_next.gray        = (delta == '0);
        data_next.lightness   = sum[CHAN_W:1];
        data_next.sat.rem     = delta_w >> 1;
        data_next.sat.divisor = sat_div;
        data_next.sat.shift   = {delta[0], {(QUOT_W-1){1'b0}}};
        data_next.hue.rem     = REM_W'(hue_num >> 1);
        data_next.hue.divisor = delta6;
        data_next.hue.shift   = {hue_num[0], {(QUOT_W-1){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: rtl/hsl_cell.sv
// ----------------------------------------------------------------------------
// HSL divider cell
// One restoring division step on the saturation and hue lanes.
// ----------------------------------------------------------------------------
module hsl_cell
    import hsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  stage_data_t data_in,
    output logic        valid_out,
    output stage_data_t data_out
);

    function automatic div_lane_t div_step(input div_lane_t lane);
        logic [REM_W:0] trial;
        logic           ge;
        div_lane_t      res;
        trial       = {lane.rem, lane.shift[QUOT_W-1]};
        ge          = (trial >= {1'b0, lane.divisor});
        res.divisor = lane.divisor;
        res.rem     = ge ? REM_W'(trial - {1'b0, lane.divisor}) : trial[REM_W-1:0];
        res.shift   = {lane.shift[QUOT_W-2:0], ge};
        return res;
    endfunction

    logic        valid_reg;
    stage_data_t data_reg;
    stage_data_t data_next;

    always_comb
    begin
        data_next           = data_in;
        data_next.sat       = div_step(data_in.sat);
        data_next.hue       = div_step(data_in.hue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per transaction into hue, saturation and
// lightness.
//
// Input: raise start with the pixel on pixel; the transaction is taken at
// any edge where start is high and busy is low. busy stays low, so a new
// pixel may enter on every clock.
// Output: done is high for one cycle with the result on result, once the
// pixel has passed one front-end stage, nine divider cells (one quotient
// bit each, shared by the saturation and hue lanes) and the output
// register. Throughput is one pixel per cycle.
// Results leave in the order the pixels entered. The receiver cannot stall
// the block and must take each result in its done cycle.
// Reset clears all valid flags; transactions in flight are dropped.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter
    import hsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rgb_pixel_t  pixel,
    output logic        done,
    output hsl_result_t result
);

    logic        stage_valid [0:QUOT_W];
    stage_data_t stage_data  [0:QUOT_W];
    logic        done_reg;
    hsl_result_t result_reg;
    hsl_result_t result_next;
    stage_data_t last;

    assign busy = 1'b0;

    hsl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (start && !busy),
        .pixel (pixel),
        .valid (stage_valid[0]),
        .data  (stage_data[0])
    );

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_cell
        hsl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[i]),
            .data_in   (stage_data[i]),
            .valid_out (stage_valid[i+1]),
            .data_out  (stage_data[i+1])
        );
    end

    assign last = stage_data[QUOT_W];

    always_comb
    begin
        result_next.lightness = last.lightness;
        if (last.gray)
        begin
            result_next.hue        = '0;
            result_next.saturation = '0;
        end
        else
        begin
            result_next.hue        = last.hue.shift[QUOT_W-1] ? '1
                                                              : last.hue.shift[CHAN_W-1:0];
            result_next.saturation = last.sat.shift[QUOT_W-1] ? '1
                                                              : last.sat.shift[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transaction");

    a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(pixel.red == pixel.green && pixel.green == pixel.blue, LATENCY)
        |-> result.hue == '0 && result.saturation == '0
            && result.lightness == $past(pixel.red, LATENCY))
        else $error("gray pixel gave nonzero hue or saturation");

    a_lightness_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(pixel.red == 8'hFF && pixel.green == 8'hFF, LATENCY)
        |-> result.lightness >= 8'd127)
        else $error("lightness below the bright channel bound");
`endif

endmodule

FILE: tb/rgb_to_hsl_converter_test.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Feeds pixels through the start/busy command port and checks every result
// strobed on done. Expected hue, saturation and lightness are computed from
// each accepted pixel, queued in order, and compared field by field with the
// results as they leave. Directed corner pixels come first, then random
// pixels with random idle bursts on the input side.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_test;
    import hsl_pkg::*;

    localparam int RANDOM_PIXELS = 850;
    localparam int QUIET_TAIL    = 120;
    localparam int CYCLE_LIMIT   = 200000;

    class hsl_scoreboard;
        hsl_result_t pending[$];
        int unsigned mismatches;

        function hsl_result_t convert(rgb_pixel_t p);
            int unsigned r, g, b, mx, mn, sum, delta, lit, divisor, num, sat, hue;
            hsl_result_t res;
            r = p.red;
            g = p.green;
            b = p.blue;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            sum   = mx + mn;
            delta = mx - mn;
            lit   = sum >> 1;
            if (delta == 0)
            begin
                sat = 0;
                hue = 0;
            end
            else
            begin
                divisor = (lit < 128) ? sum : 512 - sum;
                sat = (256 * delta) / divisor;
                if (sat > 255) sat = 255;
                if (r == mx)
                    num = (g >= b) ? g - b : 6 * delta - (b - g);
                else if (g == mx)
                    num = 2 * delta + b - r;
                else
                    num = 4 * delta + r - g;
                hue = (256 * num) / (6 * delta);
                if (hue > 255) hue = 255;
            end
            res.hue        = hue[CHAN_W-1:0];
            res.saturation = sat[CHAN_W-1:0];
            res.lightness  = lit[CHAN_W-1:0];
            return res;
        endfunction

        function void note_pixel(rgb_pixel_t p);
            pending.push_back(convert(p));
        endfunction

        function void compare_field(string name, logic [CHAN_W-1:0] want,
                                    logic [CHAN_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(hsl_result_t got);
            hsl_result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no pixel outstanding: hue %0d sat %0d light %0d",
                       got.hue, got.saturation, got.lightness);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("hue", want.hue, got.hue);
            compare_field("saturation", want.saturation, got.saturation);
            compare_field("lightness", want.lightness, got.lightness);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rgb_pixel_t  pixel;
    logic        done;
    hsl_result_t result;

    hsl_scoreboard sb = new();
    int unsigned   cycles;

    rgb_to_hsl_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (start && !busy)
                sb.note_pixel(pixel);
            if (done)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("rgb_to_hsl_converter verification failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        start       <= 1'b1;
        pixel.red   <= r;
        pixel.green <= g;
        pixel.blue  <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_burst(input int n);
        start <= 1'b0;
        pixel <= {CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom)};
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_idle(input int idx, input bit quiet);
        if (!quiet && ((idx / 64) % 3 != 2) && $urandom_range(0, 5) == 0)
            idle_burst($urandom_range(1, 17));
    endtask

    function automatic logic [CHAN_W-1:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    initial
    begin
        logic [CHAN_W-1:0] r, g, b;
        int mode;
        start <= 1'b0;
        pixel <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: grays, each sector, wrap, clamp, lightness boundary
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        maybe_idle(0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd10, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd10);
        send_pixel(8'd200, 8'd13, 8'd199);
        send_pixel(8'd1, 8'd0, 8'd0);
        idle_burst(3);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd1, 8'd100);
        send_pixel(8'd254, 8'd1, 8'd100);
        send_pixel(8'd100, 8'd255, 8'd1);
        send_pixel(8'd1, 8'd100, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd127, 8'd0);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            mode = $urandom_range(0, 9);
            r = CHAN_W'($urandom);
            g = CHAN_W'($urandom);
            b = CHAN_W'($urandom);
            case (mode)
                0:
                begin
                    g = r;
                    b = r;
                end
                1:
                begin
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                2:
                begin
                    r = edge_value();
                    g = edge_value();
                    b = edge_value();
                end
                default: ;
            endcase
            maybe_idle(i, i >= RANDOM_PIXELS - QUIET_TAIL);
            send_pixel(r, g, b);
        end

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (sb.mismatches == 0)
            $display("rgb_to_hsl_converter verification clean");
        else
            $display("rgb_to_hsl_converter verification failed");
        $finish;
    end

endmodule
